// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the bounded set stack. Empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define BSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication: when pre holds, post holds in the same cycle.
`define BSS_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication: when pre holds, post holds in the next cycle.
`define BSS_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define BSS_ASSERT(label, clk, rst, prop, msg)
`define BSS_ASSERT_IMP(label, clk, rst, pre, post, msg)
`define BSS_ASSERT_NXT(label, clk, rst, pre, post, msg)

`endif

`endif

// ===== rtl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// Shared constants, action codes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;
   localparam int ACTION_W      = 3;
   localparam int COUNT_W       = 7;

   // request action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH     = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP      = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_ADD_NEW  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REVERSE  = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_PUSH_NEW,
      ST_POP,
      ST_POP_TAKE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SHIFT_CHK,
      ST_SHIFT_WR,
      ST_REV_RD,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_START,
      DP_PUSH,
      DP_PUSH_NEW,
      DP_POP,
      DP_POP_TAKE,
      DP_SCAN_RD,
      DP_SCAN_NEXT,
      DP_FOUND,
      DP_HIT,
      DP_SHIFT_RD,
      DP_SHIFT_WR,
      DP_SHIFT_END,
      DP_REV_RD,
      DP_REV_WR_LO,
      DP_REV_WR_HI
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      clear;
      logic      rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic many;        // two or more entries
      logic match;       // last read entry equals request value
      logic hi_zero;     // scan pointer at bottom
      logic shift_more;  // entry above the shift pointer still to move
      logic rev_more;    // another swap pair left
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/bss_datapath.sv =====
// ----------------------------------------------------------------------------
// bss_datapath
// Element memory, fill count, scan/swap pointers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_datapath #(
   parameter int DEPTH = bss_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic signed [bss_pkg::VALUE_W-1:0]   req_value,
   input  wire bss_pkg::dp_cmd_type                  cmd,
   output      bss_pkg::dp_status_type               status,
   output      logic signed [bss_pkg::VALUE_W-1:0]   rsp_popped,
   output      logic                                 rsp_hit,
   output      logic        [bss_pkg::COUNT_W-1:0]   rsp_count,
   output      logic                                 rsp_overflow
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [bss_pkg::VALUE_W-1:0] mem [DEPTH];

   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] lo_ff, lo_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic signed [bss_pkg::VALUE_W-1:0] val_ff, val_in;
   logic signed [bss_pkg::VALUE_W-1:0] popped_ff, popped_in;
   logic hit_ff, hit_in;
   logic ovf_ff, ovf_in;
   logic signed [bss_pkg::VALUE_W-1:0] rd_a_ff, rd_b_ff;

   logic signed [bss_pkg::VALUE_W-1:0] rsp_popped_ff;
   logic rsp_hit_ff, rsp_ovf_ff;
   logic [bss_pkg::COUNT_W-1:0] rsp_count_ff;

   logic          wr_en, rd_a_en, rd_b_en;
   logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;
   logic signed [bss_pkg::VALUE_W-1:0] wr_data;

   assign status.empty      = (fill_ff == '0);
   assign status.full       = (fill_ff == CW'(DEPTH));
   assign status.many       = (fill_ff > CW'(1));
   assign status.match      = (rd_a_ff == val_ff);
   assign status.hi_zero    = (hi_ff == '0);
   assign status.shift_more = ((CW'(lo_ff) + CW'(1)) < fill_ff);
   assign status.rev_more   = ((CW'(lo_ff) + CW'(2)) < CW'(hi_ff));

   always_comb begin
      fill_in   = fill_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      val_in    = val_ff;
      popped_in = popped_ff;
      hit_in    = hit_ff;
      ovf_in    = ovf_ff;
      wr_en     = 1'b0;
      wr_addr   = lo_ff;
      wr_data   = rd_a_ff;
      rd_a_en   = 1'b0;
      rd_a_addr = hi_ff;
      rd_b_en   = 1'b0;
      rd_b_addr = hi_ff;
      case (cmd.op)
         bss_pkg::DP_START: begin
            val_in    = req_value;
            lo_in     = '0;
            hi_in     = AW'(fill_ff - CW'(1));
            popped_in = '0;
            hit_in    = 1'b0;
            ovf_in    = 1'b0;
         end
         bss_pkg::DP_PUSH, bss_pkg::DP_PUSH_NEW: begin
            if (status.full) begin
               ovf_in = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = AW'(fill_ff);
               wr_data = val_ff;
               fill_in = fill_ff + CW'(1);
               hit_in  = (cmd.op == bss_pkg::DP_PUSH_NEW);
            end
         end
         bss_pkg::DP_POP: begin
            if (status.empty) begin
               popped_in = '1;
            end else begin
               rd_a_en   = 1'b1;
               rd_a_addr = AW'(fill_ff - CW'(1));
               fill_in   = fill_ff - CW'(1);
               hit_in    = 1'b1;
            end
         end
         bss_pkg::DP_POP_TAKE: begin
            popped_in = rd_a_ff;
         end
         bss_pkg::DP_SCAN_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = hi_ff;
         end
         bss_pkg::DP_SCAN_NEXT: begin
            hi_in = hi_ff - AW'(1);
         end
         bss_pkg::DP_FOUND: begin
            lo_in = hi_ff;
         end
         bss_pkg::DP_HIT: begin
            hit_in = 1'b1;
         end
         bss_pkg::DP_SHIFT_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = lo_ff + AW'(1);
         end
         bss_pkg::DP_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_a_ff;
            lo_in   = lo_ff + AW'(1);
         end
         bss_pkg::DP_SHIFT_END: begin
            fill_in = fill_ff - CW'(1);
            hit_in  = 1'b1;
         end
         bss_pkg::DP_REV_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = lo_ff;
            rd_b_en   = 1'b1;
            rd_b_addr = hi_ff;
         end
         bss_pkg::DP_REV_WR_LO: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_b_ff;
         end
         bss_pkg::DP_REV_WR_HI: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = rd_a_ff;
            lo_in   = lo_ff + AW'(1);
            hi_in   = hi_ff - AW'(1);
         end
         default: begin
         end
      endcase
      if (cmd.clear) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      val_ff    <= val_in;
      popped_ff <= popped_in;
      hit_ff    <= hit_in;
      ovf_ff    <= ovf_in;
   end

   // element store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_popped_ff <= popped_ff;
         rsp_hit_ff    <= hit_ff;
         rsp_ovf_ff    <= ovf_ff;
         rsp_count_ff  <= bss_pkg::COUNT_W'(fill_ff);
      end
   end

   assign rsp_popped   = rsp_popped_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/bss_controller.sv =====
// ----------------------------------------------------------------------------
// bss_controller
// Request sequencer: steps the datapath through each action.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_controller (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [bss_pkg::ACTION_W-1:0]    req_action,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire bss_pkg::dp_status_type          status,
   output      bss_pkg::dp_cmd_type             cmd
);

   bss_pkg::state_type state_ff, state_in;
   logic [bss_pkg::ACTION_W-1:0] act_ff, act_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
   end

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      cmd.op       = bss_pkg::DP_NOP;
      cmd.clear    = 1'b0;
      cmd.rsp_load = 1'b0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bss_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = bss_pkg::DP_START;
               act_in = req_action;
               case (req_action)
                  bss_pkg::ACT_PUSH:    state_in = bss_pkg::ST_PUSH;
                  bss_pkg::ACT_POP:     state_in = bss_pkg::ST_POP;
                  bss_pkg::ACT_REMOVE,
                  bss_pkg::ACT_ADD_NEW,
                  bss_pkg::ACT_CONTAINS: state_in = bss_pkg::ST_SCAN_RD;
                  bss_pkg::ACT_REVERSE: state_in = bss_pkg::ST_REV_RD;
                  bss_pkg::ACT_CLEAR:   state_in = bss_pkg::ST_CLEAR;
                  default:              state_in = bss_pkg::ST_DONE;
               endcase
            end
         end
         bss_pkg::ST_PUSH: begin
            cmd.op   = bss_pkg::DP_PUSH;
            state_in = bss_pkg::ST_DONE;
         end
         bss_pkg::ST_PUSH_NEW: begin
            cmd.op   = bss_pkg::DP_PUSH_NEW;
            state_in = bss_pkg::ST_DONE;
         end
         bss_pkg::ST_POP: begin
            cmd.op   = bss_pkg::DP_POP;
            state_in = status.empty ? bss_pkg::ST_DONE : bss_pkg::ST_POP_TAKE;
         end
         bss_pkg::ST_POP_TAKE: begin
            cmd.op   = bss_pkg::DP_POP_TAKE;
            state_in = bss_pkg::ST_DONE;
         end
         bss_pkg::ST_SCAN_RD: begin
            if (status.empty) begin
               state_in = (act_ff == bss_pkg::ACT_ADD_NEW) ? bss_pkg::ST_PUSH_NEW
                                                           : bss_pkg::ST_DONE;
            end else begin
               cmd.op   = bss_pkg::DP_SCAN_RD;
               state_in = bss_pkg::ST_SCAN_CMP;
            end
         end
         bss_pkg::ST_SCAN_CMP: begin
            if (status.match) begin
               if (act_ff == bss_pkg::ACT_REMOVE) begin
                  cmd.op   = bss_pkg::DP_FOUND;
                  state_in = bss_pkg::ST_SHIFT_CHK;
               end else if (act_ff == bss_pkg::ACT_CONTAINS) begin
                  cmd.op   = bss_pkg::DP_HIT;
                  state_in = bss_pkg::ST_DONE;
               end else begin
                  state_in = bss_pkg::ST_DONE;
               end
            end else if (status.hi_zero) begin
               state_in = (act_ff == bss_pkg::ACT_ADD_NEW) ? bss_pkg::ST_PUSH_NEW
                                                           : bss_pkg::ST_DONE;
            end else begin
               cmd.op   = bss_pkg::DP_SCAN_NEXT;
               state_in = bss_pkg::ST_SCAN_RD;
            end
         end
         bss_pkg::ST_SHIFT_CHK: begin
            if (status.shift_more) begin
               cmd.op   = bss_pkg::DP_SHIFT_RD;
               state_in = bss_pkg::ST_SHIFT_WR;
            end else begin
               cmd.op   = bss_pkg::DP_SHIFT_END;
               state_in = bss_pkg::ST_DONE;
            end
         end
         bss_pkg::ST_SHIFT_WR: begin
            cmd.op   = bss_pkg::DP_SHIFT_WR;
            state_in = bss_pkg::ST_SHIFT_CHK;
         end
         bss_pkg::ST_REV_RD: begin
            if (status.many) begin
               cmd.op   = bss_pkg::DP_REV_RD;
               state_in = bss_pkg::ST_REV_WR_LO;
            end else begin
               state_in = bss_pkg::ST_DONE;
            end
         end
         bss_pkg::ST_REV_WR_LO: begin
            cmd.op   = bss_pkg::DP_REV_WR_LO;
            state_in = bss_pkg::ST_REV_WR_HI;
         end
         bss_pkg::ST_REV_WR_HI: begin
            cmd.op   = bss_pkg::DP_REV_WR_HI;
            state_in = status.rev_more ? bss_pkg::ST_REV_RD : bss_pkg::ST_DONE;
         end
         bss_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = bss_pkg::ST_DONE;
         end
         bss_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bss_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/bounded_set_stack.sv =====
// ----------------------------------------------------------------------------
// bounded_set_stack
// Bounded LIFO of signed 32-bit elements with membership search, topmost
// match removal, push-if-absent, reverse and clear.
// ----------------------------------------------------------------------------
//
//   channel   ports                               direction
//   -------   ---------------------------------   ---------
//   request   req_valid/req_stall, action, value  in
//   response  rsp_valid/rsp_stall, popped, hit,   out
//             count, overflow
//
// From acceptance to response load: an unused code does nothing, push and clear act once,
// pop reads the top entry, then takes it; a search reads and compares each entry from the
// top, push-if-absent then stores; remove moves each entry above the match down a place;
// reverse swaps each pair by a read and two writes. The block idles before the next request.
// Reset clears fill count and control only; no memory entry is read before it is written.
// A stalled response sits in its own register while the next request is worked on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bounded_set_stack #(
   parameter int DEPTH = bss_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire logic        [bss_pkg::ACTION_W-1:0]  req_action,
   input  wire logic signed [bss_pkg::VALUE_W-1:0]   req_value,
   // response channel
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      logic signed [bss_pkg::VALUE_W-1:0]   rsp_popped,
   output      logic                                 rsp_hit,
   output      logic        [bss_pkg::COUNT_W-1:0]   rsp_count,
   output      logic                                 rsp_overflow
);

   bss_pkg::dp_cmd_type    cmd;
   bss_pkg::dp_status_type status;

   // sequencer: walks each action through its datapath steps
   bss_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // element memory, pointers, fill count and response register
   bss_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_value),
      .cmd          (cmd),
      .status       (status),
      .rsp_popped   (rsp_popped),
      .rsp_hit      (rsp_hit),
      .rsp_count    (rsp_count),
      .rsp_overflow (rsp_overflow)
   );

   // an accepted request keeps the block busy on the following cycle
   `BSS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted but block not busy")

   // the response register is never reloaded under a stalled response
   `BSS_ASSERT_IMP(a_no_rsp_overwrite, clock, reset, cmd.rsp_load, !rsp_valid || !rsp_stall, "response overwritten while stalled")

   // a refused push never reports a hit
   `BSS_ASSERT_IMP(a_ovf_no_hit, clock, reset, rsp_valid && rsp_overflow, !rsp_hit, "overflow and hit set together")

   // full and empty are exclusive
   `BSS_ASSERT(a_full_not_empty, clock, reset, !(status.full && status.empty), "store full and empty at once")

endmodule

`default_nettype wire

// ===== verif/bounded_set_stack_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_set_stack_tb
// Self-checking bench for the bounded set stack. A shadow copy of the stack
// predicts popped/hit/count/overflow for each accepted request. Responses are
// checked in order. Directed corner cases come first, then random mixes and
// fill-to-full bursts. Both channels see random idle and stall gaps.
// ----------------------------------------------------------------------------
module bounded_set_stack_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bss_pkg::*;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int NUM_REQS     = 800;
   localparam int DRAIN_CYCLES = 400;       // well past the longest request
   localparam int CYCLE_LIMIT  = 2_000_000;

   // action code 7 has no meaning; the block must ignore it
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic        [ACTION_W-1:0] action;
      logic signed [VALUE_W-1:0]  value;
   } stack_req_t;

   typedef struct packed {
      logic signed [VALUE_W-1:0] popped;
      logic                      hit;
      logic        [COUNT_W-1:0] count;
      logic                      overflow;
   } stack_rsp_t;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow stack plus queue of predicted responses
   // -------------------------------------------------------------------------
   class stack_scoreboard;
      logic signed [VALUE_W-1:0] shadow_mem [DEPTH];
      int                        shadow_fill;
      stack_rsp_t                pending_rsp [$];
      int                        mismatch_cnt;

      function new();
         shadow_fill  = 0;
         mismatch_cnt = 0;
      endfunction

      // index of the topmost entry equal to v, -1 if absent
      function int find_topmost(logic signed [VALUE_W-1:0] v);
         int i;
         for (i = shadow_fill - 1; i >= 0; i--) begin
            if (shadow_mem[i] == v) return i;
         end
         return -1;
      endfunction

      function void note_request(logic [ACTION_W-1:0] action,
                                 logic signed [VALUE_W-1:0] value);
         stack_rsp_t                exp;
         int                        idx;
         int                        lo;
         int                        hi;
         logic signed [VALUE_W-1:0] tmp;
         exp = '0;
         case (action)
            ACT_PUSH: begin
               if (shadow_fill >= DEPTH) begin
                  exp.overflow = 1'b1;
               end else begin
                  shadow_mem[shadow_fill] = value;
                  shadow_fill++;
               end
            end
            ACT_POP: begin
               if (shadow_fill > 0) begin
                  shadow_fill--;
                  exp.popped = shadow_mem[shadow_fill];
                  exp.hit    = 1'b1;
               end else begin
                  exp.popped = -1;
               end
            end
            ACT_REMOVE: begin
               idx = find_topmost(value);
               if (idx >= 0) begin
                  // entries above the match close up the gap
                  for (lo = idx; lo + 1 < shadow_fill; lo++)
                     shadow_mem[lo] = shadow_mem[lo + 1];
                  shadow_fill--;
                  exp.hit = 1'b1;
               end
            end
            ACT_ADD_NEW: begin
               if (find_topmost(value) < 0) begin
                  if (shadow_fill >= DEPTH) begin
                     exp.overflow = 1'b1;
                  end else begin
                     shadow_mem[shadow_fill] = value;
                     shadow_fill++;
                     exp.hit = 1'b1;
                  end
               end
            end
            ACT_CONTAINS: begin
               exp.hit = (find_topmost(value) >= 0);
            end
            ACT_REVERSE: begin
               lo = 0;
               hi = shadow_fill - 1;
               while (lo < hi) begin
                  tmp            = shadow_mem[lo];
                  shadow_mem[lo] = shadow_mem[hi];
                  shadow_mem[hi] = tmp;
                  lo++;
                  hi--;
               end
            end
            ACT_CLEAR: begin
               shadow_fill = 0;
            end
            default: ;
         endcase
         exp.count = shadow_fill[COUNT_W-1:0];
         pending_rsp.push_back(exp);
      endfunction

      function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                  logic [VALUE_W-1:0] act_v);
         if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected 0x%08h actual 0x%08h",
                     $time, name, exp_v, act_v);
            mismatch_cnt++;
         end
      endfunction

      function void check_response(logic signed [VALUE_W-1:0] popped, logic hit,
                                   logic [COUNT_W-1:0] count, logic overflow);
         stack_rsp_t exp;
         if (pending_rsp.size() == 0) begin
            $display("%0t ns: response with none expected, expected none actual 0x%08h",
                     $time, popped);
            mismatch_cnt++;
            return;
         end
         exp = pending_rsp.pop_front();
         compare_field("popped",   exp.popped,   popped);
         compare_field("hit",      exp.hit,      hit);
         compare_field("count",    exp.count,    count);
         compare_field("overflow", exp.overflow, overflow);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid  = 1'b0;
   logic                       req_stall;
   logic        [ACTION_W-1:0] req_action = ACT_PUSH;
   logic signed [VALUE_W-1:0]  req_value  = '0;

   logic                       rsp_valid;
   logic                       rsp_stall  = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_popped;
   logic                       rsp_hit;
   logic        [COUNT_W-1:0]  rsp_count;
   logic                       rsp_overflow;

   initial begin
      forever #6 clock = ~clock;
   end

   bounded_set_stack #(
      .DEPTH (DEPTH)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_popped   (rsp_popped),
      .rsp_hit      (rsp_hit),
      .rsp_count    (rsp_count),
      .rsp_overflow (rsp_overflow)
   );

   stack_scoreboard sb = new();
   stack_req_t      stim_q [$];
   int              stim_total = 0;

   // -------------------------------------------------------------------------
   // Stimulus generation
   // -------------------------------------------------------------------------
   task automatic add_req(input logic [ACTION_W-1:0] action,
                          input logic signed [VALUE_W-1:0] value);
      stack_req_t item;
      item.action = action;
      item.value  = value;
      stim_q.push_back(item);
      stim_total++;
   endtask

   // mostly a small pool so that searches hit, plus extremes and full range
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return int'($urandom_range(0, 7)) - 3;
      if (r < 72) begin
         case ($urandom_range(0, 3))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return 0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // pushes slightly outweigh pops so the stack drifts toward full
   function automatic logic [ACTION_W-1:0] pick_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 28) return ACT_PUSH;
      if (r < 46) return ACT_POP;
      if (r < 58) return ACT_REMOVE;
      if (r < 72) return ACT_ADD_NEW;
      if (r < 84) return ACT_CONTAINS;
      if (r < 90) return ACT_REVERSE;
      if (r < 94) return ACT_CLEAR;
      if (r < 97) return ACT_UNUSED;
      return ACT_PUSH;
   endfunction

   task automatic gen_mix(input int n);
      int i;
      for (i = 0; i < n; i++) add_req(pick_action(), pick_value());
   endtask

   // Clear, fill to or past capacity, then work on a full stack: refused pushes,
   // deep search/remove and a full-length reverse.
   task automatic gen_fill_burst();
      int                        n;
      int                        i;
      logic signed [VALUE_W-1:0] bottom;
      logic signed [VALUE_W-1:0] mid;
      logic signed [VALUE_W-1:0] v;
      add_req(ACT_CLEAR, $urandom);
      bottom = $urandom;
      mid    = bottom;
      add_req(ACT_PUSH, bottom);
      n = $urandom_range(DEPTH - 2, DEPTH + 4);
      for (i = 1; i <= n; i++) begin
         v = $urandom;
         if (i == DEPTH / 2) mid = v;
         add_req($urandom_range(0, 1) ? ACT_PUSH : ACT_ADD_NEW, v);
      end
      add_req(ACT_PUSH, $urandom);
      add_req(ACT_ADD_NEW, $urandom);
      add_req(ACT_ADD_NEW, mid);
      add_req(ACT_CONTAINS, bottom);
      add_req(ACT_CONTAINS, $urandom);
      add_req(ACT_REVERSE, $urandom);
      add_req(ACT_REMOVE, mid);
      add_req(ACT_REMOVE, bottom);
      add_req(ACT_REMOVE, $urandom);
      add_req(ACT_PUSH, $urandom);
      add_req(ACT_REVERSE, $urandom);
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) add_req(ACT_POP, $urandom);
   endtask

   task automatic build_stimulus();
      // directed corner cases
      add_req(ACT_PUSH,     VAL_MAX);
      add_req(ACT_PUSH,     VAL_MIN);
      add_req(ACT_PUSH,     0);
      add_req(ACT_PUSH,     -1);
      add_req(ACT_PUSH,     1);
      add_req(ACT_CONTAINS, VAL_MAX);      // bottom entry, full scan
      add_req(ACT_CONTAINS, 2);            // miss
      add_req(ACT_ADD_NEW,  -1);           // already present, nothing stored
      add_req(ACT_ADD_NEW,  2);            // absent, inserted
      add_req(ACT_REMOVE,   VAL_MIN);      // middle entry, rest closes up
      add_req(ACT_REMOVE,   12345);        // absent value
      add_req(ACT_REVERSE,  0);
      add_req(ACT_UNUSED,   -1);           // ignored code
      add_req(ACT_POP,      0);
      add_req(ACT_POP,      0);
      add_req(ACT_POP,      0);
      add_req(ACT_POP,      0);
      add_req(ACT_POP,      0);
      add_req(ACT_POP,      VAL_MAX);      // pop on empty
      add_req(ACT_REVERSE,  0);            // reverse on empty
      add_req(ACT_PUSH,     42);
      add_req(ACT_REVERSE,  0);            // reverse of one entry
      add_req(ACT_PUSH,     42);
      add_req(ACT_REMOVE,   42);           // duplicate: topmost goes first
      add_req(ACT_CLEAR,    VAL_MIN);

      // random part: mixes with occasional fill bursts
      while (stim_total < NUM_REQS) begin
         if ($urandom_range(0, 9) < 2) gen_fill_burst();
         else gen_mix($urandom_range(10, 40));
      end
   endtask

   // idle length: mostly zero or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: valid drops only after acceptance, payload held while
   // stalled. req_calm gives runs of back-to-back requests.
   // -------------------------------------------------------------------------
   int         req_gap  = 0;
   int         req_calm = 0;
   stack_req_t req_next;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // previous request accepted at this edge
         if (req_valid) sb.note_request(req_action, req_value);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (stim_q.size() > 0) begin
            req_next = stim_q.pop_front();
            req_valid  <= 1'b1;
            req_action <= req_next.action;
            req_value  <= req_next.value;
            if (req_calm > 0) begin
               req_calm--;
               req_gap = 0;
            end else begin
               req_gap = idle_len();
               if ($urandom_range(0, 99) < 3) req_calm = $urandom_range(20, 60);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor and stall generator. Stall is independent of valid.
   // -------------------------------------------------------------------------
   int rsp_hold = 0;
   int rsp_calm = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_popped, rsp_hit, rsp_count, rsp_overflow);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_calm > 0) begin
            rsp_calm--;
         end else begin
            if ($urandom_range(0, 99) < 25) rsp_hold = idle_len();
            if ($urandom_range(0, 199) == 0) rsp_calm = $urandom_range(50, 300);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Run control
   // -------------------------------------------------------------------------
   initial begin
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // poll on the falling edge, clear of the posedge updates
      do @(negedge clock);
      while (!(stim_q.size() == 0 && !req_valid && sb.pending_rsp.size() == 0));
      // catch any stray response after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_cnt == 0 && sb.pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   int unsigned cycle_cnt = 0;

   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("%0t ns: timeout after %0d cycles", $time, cycle_cnt);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bss_pkg.sv
rtl/bss_datapath.sv
rtl/bss_controller.sv
rtl/bounded_set_stack.sv
verif/bounded_set_stack_tb.sv
